>>> hw/rtl/cfrx_pkg.sv
// Shared constants, types and the CRC-8 step function of the COBS frame receiver.
`timescale 1ns / 1ps
package cfrx_pkg;

  // Default depth of the frame store in bytes.
  localparam int MAX_FRAME_BYTES_DEF = 64;

  // Configuration register widths, indexes and reset values.
  localparam int PLEN_W      = 7;
  localparam int CRC_OFF_W   = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_OFFSET    = 1'd1;
  localparam logic [PLEN_W-1:0]    PLEN_RESET        = 7'd16;
  localparam logic [CRC_OFF_W-1:0] CRC_OFF_RESET     = 6'd15;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;

  // Byte constants of the COBS framing and of the CRC.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] CODE_FULL = 8'hFF;
  localparam logic [7:0] CRC_MSB   = 8'h80;
  localparam logic [7:0] CRC_POLY  = 8'h31;

  // Frame-end verdict from the decoder to the store.
  typedef struct packed {
    logic done;
    logic bad_len;
    logic bad_crc;
  } cfrx_verdict_t;

  // One CRC-8 byte step, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != BYTE_ZERO) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cfrx_decoder.sv
// COBS byte decoder with length count, CRC-8 accumulation and frame-end verdict.
`timescale 1ns / 1ps
module cfrx_decoder #(
  parameter int MAX_FRAME_BYTES = cfrx_pkg::MAX_FRAME_BYTES_DEF,
  parameter int AW              = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [7:0]                     rx_byte,
  input  logic [cfrx_pkg::PLEN_W-1:0]    plen,
  input  logic [cfrx_pkg::CRC_OFF_W-1:0] crc_off,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [7:0]                     wr_data,
  output cfrx_pkg::cfrx_verdict_t        verdict
);
  import cfrx_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int XW = (CW > PLEN_W) ? CW : PLEN_W;

  logic [7:0]    grp_r, grp_nxt;
  logic          zp_r, zp_nxt;
  logic [1:0]    enc_r, enc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    rcrc_r, rcrc_nxt;

  logic          do_commit;
  logic [7:0]    cval;
  logic [7:0]    crc_in;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] plen_x;
  logic [XW-1:0] off_x;
  logic          len_bad;

  assign cnt_x  = XW'(cnt_r);
  assign plen_x = XW'(plen);
  assign off_x  = XW'(crc_off);

  // Length check of the frame collected so far.
  assign len_bad = ovf_r || (plen == '0) || (plen_x > XW'(MAX_FRAME_BYTES)) ||
                   (cnt_x != plen_x);

  // Decode one byte; commit a data byte or the held-back zero.
  always_comb begin
    grp_nxt   = grp_r;
    zp_nxt    = zp_r;
    enc_nxt   = enc_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    do_commit = 1'b0;
    cval      = rx_byte;
    crc_in    = rx_byte;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = rx_byte;
    verdict   = '0;
    if (accept) begin
      if (rx_byte != BYTE_ZERO) begin
        if (enc_r != 2'd2) begin
          enc_nxt = enc_r + 2'd1;
        end
        if (grp_r == BYTE_ZERO) begin
          do_commit = zp_r;
          cval      = BYTE_ZERO;
          grp_nxt   = rx_byte - 8'd1;
          zp_nxt    = (rx_byte != CODE_FULL);
        end else begin
          do_commit = 1'b1;
          cval      = rx_byte;
          grp_nxt   = grp_r - 8'd1;
        end
        if (do_commit) begin
          if (cnt_r >= CW'(MAX_FRAME_BYTES)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_data = cval;
            crc_in  = cval;
            if (cnt_x == off_x) begin
              rcrc_nxt = cval;
              crc_in   = BYTE_ZERO;
            end
            crc_nxt = crc8_step(crc_r, crc_in);
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end else begin
        // Frame end: report unless the frame was too short, then clear.
        if (enc_r == 2'd2) begin
          verdict.done    = 1'b1;
          verdict.bad_len = len_bad;
          verdict.bad_crc = !len_bad && (crc_r != rcrc_r);
        end
        grp_nxt  = BYTE_ZERO;
        zp_nxt   = 1'b0;
        enc_nxt  = 2'd0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        crc_nxt  = BYTE_ZERO;
        rcrc_nxt = BYTE_ZERO;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r  <= BYTE_ZERO;
      zp_r   <= 1'b0;
      enc_r  <= 2'd0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      crc_r  <= BYTE_ZERO;
      rcrc_r <= BYTE_ZERO;
    end else begin
      grp_r  <= grp_nxt;
      zp_r   <= zp_nxt;
      enc_r  <= enc_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      crc_r  <= crc_nxt;
      rcrc_r <= rcrc_nxt;
    end
  end

endmodule

>>> hw/rtl/cfrx_store.sv
// Frame store memory, read-out sequencer and output register.
`timescale 1ns / 1ps
module cfrx_store #(
  parameter int MAX_FRAME_BYTES = cfrx_pkg::MAX_FRAME_BYTES_DEF,
  parameter int AW              = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [7:0]                  wr_data,
  input  cfrx_pkg::cfrx_verdict_t     verdict,
  input  logic [cfrx_pkg::PLEN_W-1:0] plen,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_data_byte,
  output logic [1:0]                  out_status,
  output logic                        out_last
);
  import cfrx_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int XW = (CW > PLEN_W) ? CW : PLEN_W;

  logic [7:0]    mem [MAX_FRAME_BYTES];
  logic [7:0]    rd_data_r;
  logic          emit_r;
  logic [CW-1:0] rd_idx_r;
  logic          out_valid_r;
  logic          is_data_r;
  logic [1:0]    status_r;
  logic          last_r;
  logic          adv;
  logic          rd_en;
  logic          rd_last;

  // The output register can take a new item this cycle.
  assign adv     = !out_valid_r || !out_stall;
  assign rd_en   = emit_r && adv && !verdict.done;
  assign rd_last = (XW'(rd_idx_r) + XW'(1)) == XW'(plen);
  assign busy    = emit_r || (out_valid_r && out_stall);

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // Read-out sequencer and output control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
      is_data_r   <= 1'b0;
      status_r    <= ST_OK;
      last_r      <= 1'b0;
    end else if (verdict.done) begin
      if (verdict.bad_len || verdict.bad_crc) begin
        out_valid_r <= 1'b1;
        is_data_r   <= 1'b0;
        status_r    <= verdict.bad_len ? ST_BAD_LEN : ST_BAD_CRC;
        last_r      <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
        emit_r      <= 1'b1;
        rd_idx_r    <= '0;
      end
    end else if (rd_en) begin
      out_valid_r <= 1'b1;
      is_data_r   <= 1'b1;
      status_r    <= ST_OK;
      last_r      <= rd_last;
      rd_idx_r    <= rd_idx_r + CW'(1);
      if (rd_last) begin
        emit_r <= 1'b0;
      end
    end else if (adv) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = is_data_r ? rd_data_r : BYTE_ZERO;
  assign out_status    = status_r;
  assign out_last      = last_r;

endmodule

>>> hw/rtl/cobs_frame_receiver_crc8.sv
// Top level of the COBS frame receiver with CRC-8 check.
`timescale 1ns / 1ps
// Received bytes enter on the in_ channel (in_valid, in_stall, in_rx_byte);
// a zero byte ends a frame. Each accepted byte is decoded combinationally and
// decoded bytes are written into the frame store memory.
// At a frame end with at least two encoded bytes, a frame of packet_length
// bytes with a matching CRC is sent on the out_ channel one byte per cycle
// while out_stall is low, read from the store through its registered read
// port, with out_last on the final byte; the first byte follows the zero
// byte through emit_r, then the read port. A bad frame gives one status item
// in the cycle after the zero byte. One received byte is taken per cycle
// while in_stall is low; a good frame holds the input during its read-out.
// in_stall is raised while a frame is read out, and whenever an output item
// is waiting under out_stall; nothing is lost or repeated under stall.
// The cfg_ channel writes packet_length (index 0) and crc_offset (index 1)
// and is always ready; write it only while the block is idle.
// Synchronous reset sets packet_length to 16, crc_offset to 15 and clears
// the frame state; the store needs no clearing.
module cobs_frame_receiver_crc8 #(
  parameter int MAX_FRAME_BYTES = cfrx_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_data_byte,
  output logic [1:0]                      out_status,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfrx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfrx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfrx_pkg::*;

  localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  logic [PLEN_W-1:0]    plen_r;
  logic [CRC_OFF_W-1:0] crc_off_r;
  logic                 accept;
  logic                 busy;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  cfrx_verdict_t        verdict;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= PLEN_RESET;
      crc_off_r <= CRC_OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PACKET_LENGTH: plen_r    <= cfg_data[PLEN_W-1:0];
        CFG_CRC_OFFSET:    crc_off_r <= cfg_data[CRC_OFF_W-1:0];
        default: ;
      endcase
    end
  end

  cfrx_decoder #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .AW             (AW)
  ) u_decoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rx_byte(in_rx_byte),
    .plen   (plen_r),
    .crc_off(crc_off_r),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .verdict(verdict)
  );

  cfrx_store #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .AW             (AW)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .verdict      (verdict),
    .plen         (plen_r),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_byte(out_data_byte),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the COBS frame receiver with its CRC-8 check.
`timescale 1ns / 1ps
module tb_top;
  import cfrx_pkg::*;

  localparam int MAX_BYTES    = MAX_FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 16;

  // One result request of the block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } frame_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_data_byte;
  logic [1:0] out_status;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Decoder state as the predictor sees it.
  logic [7:0] grp_left;
  logic       zero_held;
  int         enc_seen;
  int         dec_len;
  logic       len_ovf;
  logic [7:0] crc_run;
  logic [7:0] crc_got;
  logic [7:0] frame_mem [MAX_BYTES];
  int         plen_cfg;
  int         crc_pos_cfg;

  // Results still owed by the block, oldest first.
  frame_item_t frame_out_q[$];
  frame_item_t head;

  // Frame contents under construction by the stimulus tasks.
  logic [7:0] payload_buf[$];

  int fail_count;
  int rx_sent;
  int cycle_count;
  int gap_max;
  int stall_max;
  int hold_req;

  cobs_frame_receiver_crc8 u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_byte(out_data_byte),
    .out_status   (out_status),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // CRC-8, polynomial 0x31, MSB first.
  function automatic logic [7:0] crc8_shift(input logic [7:0] acc, input logic [7:0] v);
    logic [7:0] r;
    r = acc ^ v;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic void expect_item(input logic [7:0] d, input logic [1:0] st,
                                      input logic lst);
    frame_item_t it;
    it.data_byte = d;
    it.status    = st;
    it.last      = lst;
    frame_out_q = {frame_out_q, it};
  endfunction

  function automatic void clear_frame_state();
    grp_left  = BYTE_ZERO;
    zero_held = 1'b0;
    enc_seen  = 0;
    dec_len   = 0;
    len_ovf   = 1'b0;
    crc_run   = BYTE_ZERO;
    crc_got   = BYTE_ZERO;
  endfunction

  // Store one decoded byte and run it through the CRC; the CRC slot enters as zero.
  function automatic void store_decoded(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    if (dec_len >= MAX_BYTES) begin
      len_ovf = 1'b1;
    end else begin
      frame_mem[dec_len] = v;
      if (dec_len == crc_pos_cfg) begin
        crc_got = v;
        c = BYTE_ZERO;
      end
      crc_run = crc8_shift(crc_run, c);
      dec_len++;
    end
  endfunction

  // Predict the results of one accepted received byte.
  function automatic void decode_rx_byte(input logic [7:0] b);
    if (b != BYTE_ZERO) begin
      if (enc_seen < 2) enc_seen++;
      if (grp_left == BYTE_ZERO) begin
        // A code byte commits the zero that closed the previous group.
        if (zero_held) store_decoded(BYTE_ZERO);
        grp_left  = b - 8'd1;
        zero_held = (b != CODE_FULL);
      end else begin
        store_decoded(b);
        grp_left = grp_left - 8'd1;
      end
    end else begin
      if (enc_seen >= 2) begin
        if (len_ovf || plen_cfg == 0 || plen_cfg > MAX_BYTES || dec_len != plen_cfg) begin
          expect_item(BYTE_ZERO, ST_BAD_LEN, 1'b1);
        end else if (crc_run != crc_got) begin
          expect_item(BYTE_ZERO, ST_BAD_CRC, 1'b1);
        end else begin
          for (int i = 0; i < plen_cfg; i++) begin
            expect_item(frame_mem[i], ST_OK, i == plen_cfg - 1);
          end
        end
      end
      clear_frame_state();
    end
  endfunction

  // Compare each taken result request with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_out_q.size() == 0) begin
        $error("unexpected result: data_byte %02h status %0d last %0d",
               out_data_byte, out_status, out_last);
        fail_count++;
      end else begin
        head = frame_out_q.pop_front();
        if (out_data_byte !== head.data_byte) begin
          $error("data_byte mismatch: expected %02h, got %02h", head.data_byte, out_data_byte);
          fail_count++;
        end
        if (out_status !== head.status) begin
          $error("status mismatch: expected %0d, got %0d", head.status, out_status);
          fail_count++;
        end
        if (out_last !== head.last) begin
          $error("last mismatch: expected %0d, got %0d", head.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Receiver side: a random stall before each result, or one long hold when asked.
  initial begin : result_stall_gen
    int n;
    int holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != hold_req) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = $urandom_range(0, stall_max);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && holds_done == hold_req);
    end
  end

  // Offer one byte request after a random gap and wait until it is taken.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_rx_byte(b);
    rx_sent++;
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    park_input();
    while (frame_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PACKET_LENGTH) plen_cfg = data;
    else crc_pos_cfg = data[CRC_OFF_W-1:0];
  endtask

  // Content bytes lean toward zero and the other corner values.
  function automatic logic [7:0] pick_content_byte();
    case ($urandom_range(0, 7))
      0, 1:    return BYTE_ZERO;
      2:       return CODE_FULL;
      3:       return ($urandom_range(0, 1) != 0) ? CRC_MSB : 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void fill_payload(input int len);
    payload_buf.delete();
    for (int i = 0; i < len; i++) payload_buf = {payload_buf, pick_content_byte()};
  endfunction

  // Place a CRC that makes the frame check out; with the slot past the end, the
  // last byte is chosen so the CRC over the whole frame comes out zero.
  function automatic void seal_payload();
    logic [7:0] acc;
    int n;
    acc = BYTE_ZERO;
    n = payload_buf.size();
    if (crc_pos_cfg < n) begin
      for (int i = 0; i < n; i++) begin
        acc = crc8_shift(acc, (i == crc_pos_cfg) ? BYTE_ZERO : payload_buf[i]);
      end
      payload_buf[crc_pos_cfg] = acc;
    end else if (n > 0) begin
      for (int i = 0; i < n - 1; i++) acc = crc8_shift(acc, payload_buf[i]);
      payload_buf[n-1] = acc;
    end
  endfunction

  // COBS-encode the payload and send it; a nonzero cut below the encoded length ends the frame early.
  task automatic send_frame(input int cut);
    logic [7:0] enc[$];
    int code_at;
    int n;
    logic [7:0] code;
    enc = {enc, BYTE_ZERO};
    code_at = 0;
    code = 8'd1;
    foreach (payload_buf[i]) begin
      if (payload_buf[i] == BYTE_ZERO) begin
        enc[code_at] = code;
        code_at = enc.size();
        enc = {enc, BYTE_ZERO};
        code = 8'd1;
      end else begin
        enc = {enc, payload_buf[i]};
        code = code + 8'd1;
        if (code == CODE_FULL) begin
          enc[code_at] = code;
          code_at = enc.size();
          enc = {enc, BYTE_ZERO};
          code = 8'd1;
        end
      end
    end
    enc[code_at] = code;
    n = (cut > 0 && cut < enc.size()) ? cut : enc.size();
    for (int i = 0; i < n; i++) send_rx_byte(enc[i]);
    send_rx_byte(BYTE_ZERO);
  endtask

  task automatic send_good_frame(input int len);
    fill_payload(len);
    seal_payload();
    send_frame(0);
  endtask

  // Reset values: a 16-byte frame with its CRC in the last slot.
  task automatic test_default_config();
    payload_buf = {8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h55,
                   8'hAA, 8'hFE, 8'h02, 8'h00, 8'h10, 8'h20, 8'h40, 8'h00};
    seal_payload();
    send_frame(0);
  endtask

  // Frames of at most one encoded byte vanish; two encoded bytes already count.
  task automatic test_short_frames();
    send_rx_byte(BYTE_ZERO);
    send_rx_byte(8'h05);
    send_rx_byte(BYTE_ZERO);
    send_rx_byte(8'h01);
    send_rx_byte(8'h01);
    send_rx_byte(BYTE_ZERO);
  endtask

  // A full-length code carries no implied zero; the frame ends inside its group.
  task automatic test_code_ff_groups();
    send_rx_byte(CODE_FULL);
    send_rx_byte(8'h11);
    send_rx_byte(8'h22);
    send_rx_byte(BYTE_ZERO);
  endtask

  // Smallest length with a good and a bad CRC, then lengths that can never match.
  task automatic test_length_limits();
    write_reg(CFG_PACKET_LENGTH, 7'd1);
    write_reg(CFG_CRC_OFFSET, 7'd0);
    send_good_frame(1);
    payload_buf = {8'h5A};
    send_frame(0);
    write_reg(CFG_PACKET_LENGTH, 7'd0);
    send_good_frame(1);
    write_reg(CFG_PACKET_LENGTH, 7'h7F);
    send_good_frame(3);
  endtask

  // CRC slot past the frame end: the CRC over all bytes must come out zero.
  task automatic test_crc_outside_frame();
    write_reg(CFG_PACKET_LENGTH, 7'd3);
    write_reg(CFG_CRC_OFFSET, 7'h7F);
    send_good_frame(3);
    payload_buf = {8'h12, 8'h00, 8'h34};
    send_frame(0);
  endtask

  // Largest accepted frame, then one that runs past the store.
  task automatic test_length_overflow();
    write_reg(CFG_PACKET_LENGTH, 7'(MAX_BYTES));
    write_reg(CFG_CRC_OFFSET, 7'(MAX_BYTES - 1));
    send_good_frame(MAX_BYTES);
    send_good_frame(MAX_BYTES + 6);
  endtask

  // The receiver holds off while back-to-back frames pile up behind it.
  task automatic test_output_backpressure();
    write_reg(CFG_PACKET_LENGTH, 7'd24);
    write_reg(CFG_CRC_OFFSET, 7'd5);
    gap_max = 0;
    hold_req++;
    repeat (4) send_good_frame(24);
    gap_max = 4;
  endtask

  // Config phases with mostly well-formed frames and some damaged ones.
  task automatic test_random_traffic();
    int start;
    int plen;
    int len;
    int cut;
    int n;
    logic [5:0] pos;
    start = rx_sent;
    while (rx_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       plen = MAX_BYTES;
        1:       plen = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(MAX_BYTES + 1, 127);
        2:       plen = $urandom_range(13, 40);
        default: plen = $urandom_range(1, 12);
      endcase
      if (plen >= 1 && plen <= MAX_BYTES && $urandom_range(0, 4) != 0) begin
        pos = 6'($urandom_range(0, plen - 1));
      end else begin
        pos = 6'($urandom_range(0, 63));
      end
      write_reg(CFG_PACKET_LENGTH, 7'(plen));
      write_reg(CFG_CRC_OFFSET, {1'($urandom_range(0, 1)), pos});
      gap_max   = ($urandom_range(0, 2) != 0) ? 4 : 0;
      stall_max = ($urandom_range(0, 2) != 0) ? 4 : 0;
      repeat ($urandom_range(3, 8)) begin
        if (rx_sent - start >= RANDOM_ITEMS) break;
        len = (plen >= 1 && plen <= MAX_BYTES) ? plen : $urandom_range(1, 10);
        case ($urandom_range(0, 9))
          6: begin
            // Group cut short by an early frame end.
            fill_payload(len);
            seal_payload();
            cut = $urandom_range(1, len + 1);
            send_frame(cut);
          end
          7: begin
            if ($urandom_range(0, 1) != 0) len = len + $urandom_range(1, 3);
            else len = (len > 3) ? len - $urandom_range(1, 3) : 0;
            send_good_frame(len);
          end
          8: begin
            fill_payload(len);
            seal_payload();
            n = $urandom_range(0, len - 1);
            payload_buf[n] = payload_buf[n] ^ 8'($urandom_range(1, 255));
            send_frame(0);
          end
          9: begin
            // Raw line noise, closed by a frame end.
            repeat ($urandom_range(1, 12)) send_rx_byte(pick_content_byte());
            send_rx_byte(BYTE_ZERO);
          end
          default: send_good_frame(len);
        endcase
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_rx_byte   <= BYTE_ZERO;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_PACKET_LENGTH;
    cfg_data     <= '0;
    rx_sent      = 0;
    gap_max      = 4;
    stall_max    = 4;
    hold_req     = 0;
    plen_cfg     = PLEN_RESET;
    crc_pos_cfg  = CRC_OFF_RESET;
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_config();
    test_short_frames();
    test_code_ff_groups();
    test_length_limits();
    test_crc_outside_frame();
    test_length_overflow();
    test_output_backpressure();
    test_random_traffic();

    // Drain whatever the block still owes, then allow for its latency.
    park_input();
    while (frame_out_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cfrx_pkg.sv
hw/rtl/cfrx_decoder.sv
hw/rtl/cfrx_store.sv
hw/rtl/cobs_frame_receiver_crc8.sv
tb/tb_top.sv
